// ===== design/dds_pkg.sv =====
package dds_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_CONF_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_CONFIRM_FRAMES = 2'd1;
   localparam logic [1:0] REG_LOSS_FRAMES    = 2'd2;
   localparam logic [1:0] REG_SMOOTH_WEIGHT  = 2'd3;

   // reset values of the configuration registers
   localparam logic [15:0] CONF_THRESHOLD_RESET = 16'd16384;
   localparam logic [3:0]  CONFIRM_FRAMES_RESET = 4'd4;
   localparam logic [7:0]  LOSS_FRAMES_RESET    = 8'd8;
   localparam logic [15:0] SMOOTH_WEIGHT_RESET  = 16'd9830;

   // unity in Q0.16, one bit wider than a sample
   localparam logic [16:0] Q16_ONE     = 17'h10000;
   localparam logic [7:0]  MISSED_MAX  = 8'hFF;

   typedef struct packed {
      logic [15:0] conf_threshold;
      logic [3:0]  confirm_frames;
      logic [7:0]  loss_frames;
      logic [15:0] smooth_weight;
   } cfg_type;

   typedef struct packed {
      logic        box_present;
      logic [15:0] confidence;
      logic [15:0] box_x;
      logic [15:0] box_y;
      logic [15:0] box_width;
      logic [15:0] box_height;
   } item_type;

   typedef struct packed {
      logic        target_present;
      logic [15:0] target_cx;
      logic [15:0] target_y;
      logic [15:0] target_w;
      logic [15:0] target_h;
   } result_type;

endpackage

// ===== design/dds_blend.sv =====
module dds_blend (
   input  logic [15:0] weight,
   input  logic [15:0] old_value,
   input  logic [15:0] sample,
   output logic [15:0] blended
);

   logic [16:0] inv_weight;
   logic [32:0] prod_old;
   logic [32:0] prod_new;
   logic [32:0] acc;

   // old*(1-a) + in*a, truncated back to Q0.16
   assign inv_weight = dds_pkg::Q16_ONE - {1'b0, weight};
   assign prod_old   = 33'(old_value) * 33'(inv_weight);
   assign prod_new   = 33'(sample) * 33'(weight);
   assign acc        = prod_old + prod_new;
   assign blended    = acc[31:16];

endmodule

// ===== design/detection_debounce_smoother_core.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | box_present, confidence, box_x/y/width/height
// rsp     | out       | rsp_valid/rsp_ready  | target_present, target_cx, target_y/w/h
// csr     | in        | csr_write_en         | csr_index, csr_wdata
//
// one item per cycle while rsp_ready holds; an item is taken into the input register, and its
// result is offered once the debounce and filter update has loaded it into the result register
// the width and height filters use two multipliers each (17x16 and 16x16), all in the update cycle
// reset is synchronous, restores the configuration defaults and clears tracking state and valid flags
// a stalled result holds; one more item waits in the input register, then req_ready drops
module detection_debounce_smoother_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_box_present,
   input  logic [15:0] req_confidence,
   input  logic [15:0] req_box_x,
   input  logic [15:0] req_box_y,
   input  logic [15:0] req_box_width,
   input  logic [15:0] req_box_height,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_target_present,
   output logic [15:0] rsp_target_cx,
   output logic [15:0] rsp_target_y,
   output logic [15:0] rsp_target_w,
   output logic [15:0] rsp_target_h,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dds_pkg::cfg_type    cfg_ff;
   dds_pkg::item_type   item_ff;
   dds_pkg::result_type result_ff;
   dds_pkg::result_type result_in;
   logic                item_valid_ff;
   logic                rsp_valid_ff;
   logic                advance;
   logic                out_free;

   logic [3:0]  seen_ff,    seen_in;
   logic [7:0]  missed_ff,  missed_in;
   logic        present_ff, present_in;
   logic [15:0] filt_w_ff,  filt_w_in;
   logic [15:0] filt_h_ff,  filt_h_in;
   logic [15:0] hold_x_ff,  hold_x_in;
   logic [15:0] hold_y_ff,  hold_y_in;
   logic [15:0] hold_w_ff,  hold_w_in;
   logic [15:0] hold_h_ff,  hold_h_in;

   logic        frame_valid;
   logic [15:0] blend_w;
   logic [15:0] blend_h;
   logic [3:0]  seen_step;
   logic [7:0]  missed_step;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_threshold <= dds_pkg::CONF_THRESHOLD_RESET;
         cfg_ff.confirm_frames <= dds_pkg::CONFIRM_FRAMES_RESET;
         cfg_ff.loss_frames    <= dds_pkg::LOSS_FRAMES_RESET;
         cfg_ff.smooth_weight  <= dds_pkg::SMOOTH_WEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            dds_pkg::REG_CONF_THRESHOLD: cfg_ff.conf_threshold <= csr_wdata;
            dds_pkg::REG_CONFIRM_FRAMES: cfg_ff.confirm_frames <= csr_wdata[3:0];
            dds_pkg::REG_LOSS_FRAMES:    cfg_ff.loss_frames    <= csr_wdata[7:0];
            dds_pkg::REG_SMOOTH_WEIGHT:  cfg_ff.smooth_weight  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // handshake: the input register moves on when the result register is free
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.box_present <= req_box_present;
         item_ff.confidence  <= req_confidence;
         item_ff.box_x       <= req_box_x;
         item_ff.box_y       <= req_box_y;
         item_ff.box_width   <= req_box_width;
         item_ff.box_height  <= req_box_height;
      end
   end

   // size filters
   dds_blend u_blend_w (
      .weight    (cfg_ff.smooth_weight),
      .old_value (filt_w_ff),
      .sample    (item_ff.box_width),
      .blended   (blend_w)
   );

   dds_blend u_blend_h (
      .weight    (cfg_ff.smooth_weight),
      .old_value (filt_h_ff),
      .sample    (item_ff.box_height),
      .blended   (blend_h)
   );

   // debounce and hold update
   assign frame_valid = item_ff.box_present && (item_ff.confidence > cfg_ff.conf_threshold);
   assign seen_step   = (seen_ff < cfg_ff.confirm_frames) ? seen_ff + 4'd1 : seen_ff;
   assign missed_step = (missed_ff != dds_pkg::MISSED_MAX) ? missed_ff + 8'd1 : missed_ff;

   always_comb begin
      seen_in    = seen_ff;
      missed_in  = missed_ff;
      present_in = present_ff;
      filt_w_in  = filt_w_ff;
      filt_h_in  = filt_h_ff;
      hold_x_in  = hold_x_ff;
      hold_y_in  = hold_y_ff;
      hold_w_in  = hold_w_ff;
      hold_h_in  = hold_h_ff;
      if (frame_valid) begin
         missed_in = 8'd0;
         seen_in   = seen_step;
         if (seen_step >= cfg_ff.confirm_frames) begin
            present_in = 1'b1;
            hold_x_in  = item_ff.box_x;
            hold_y_in  = item_ff.box_y;
            // first lock loads the box size directly
            if (filt_w_ff == 16'd0) begin
               filt_w_in = item_ff.box_width;
               filt_h_in = item_ff.box_height;
            end else begin
               filt_w_in = blend_w;
               filt_h_in = blend_h;
            end
            hold_w_in = filt_w_in;
            hold_h_in = filt_h_in;
         end
      end else begin
         seen_in = 4'd0;
         if (present_ff) begin
            missed_in = missed_step;
            if (missed_step >= cfg_ff.loss_frames) begin
               present_in = 1'b0;
               filt_w_in  = 16'd0;
               filt_h_in  = 16'd0;
            end
         end
      end
   end

   assign result_in.target_present = present_in;
   assign result_in.target_cx      = hold_x_in;
   assign result_in.target_y       = hold_y_in;
   assign result_in.target_w       = hold_w_in;
   assign result_in.target_h       = hold_h_in;

   // tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= 4'd0;
         missed_ff  <= 8'd0;
         present_ff <= 1'b0;
         filt_w_ff  <= 16'd0;
         filt_h_ff  <= 16'd0;
         hold_x_ff  <= 16'd0;
         hold_y_ff  <= 16'd0;
         hold_w_ff  <= 16'd0;
         hold_h_ff  <= 16'd0;
      end else if (advance) begin
         seen_ff    <= seen_in;
         missed_ff  <= missed_in;
         present_ff <= present_in;
         filt_w_ff  <= filt_w_in;
         filt_h_ff  <= filt_h_in;
         hold_x_ff  <= hold_x_in;
         hold_y_ff  <= hold_y_in;
         hold_w_ff  <= hold_w_in;
         hold_h_ff  <= hold_h_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target_present = result_ff.target_present;
   assign rsp_target_cx      = result_ff.target_cx;
   assign rsp_target_y       = result_ff.target_y;
   assign rsp_target_w       = result_ff.target_w;
   assign rsp_target_h       = result_ff.target_h;

   // input side stalls only when both registers hold an item
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (item_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("req_ready low without a full pipeline");

   // an invalid frame clears the run of valid frames
   assert property (@(posedge clock) disable iff (reset)
      (advance && !frame_valid) |=> (seen_ff == 4'd0))
      else $error("seen count not cleared by an invalid frame");

   // presence only rises on a valid frame
   assert property (@(posedge clock) disable iff (reset)
      $rose(present_ff) |-> $past(advance && frame_valid))
      else $error("target present set without a valid frame");

   // dropping the target clears both filters
   assert property (@(posedge clock) disable iff (reset)
      $fell(present_ff) |-> (filt_w_ff == 16'd0 && filt_h_ff == 16'd0))
      else $error("filters not cleared on target drop");

endmodule

// ===== bench/detection_debounce_smoother_core_test.sv =====
module detection_debounce_smoother_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // one directed step: optional register load, the item, and an optional typed-in result
   typedef struct packed {
      logic                load_cfg;
      dds_pkg::cfg_type    cfg;
      dds_pkg::item_type   frame;
      logic                typed;
      dds_pkg::result_type want;
   } step_row_type;

   localparam dds_pkg::cfg_type CFG_RST = '{dds_pkg::CONF_THRESHOLD_RESET,
                                            dds_pkg::CONFIRM_FRAMES_RESET,
                                            dds_pkg::LOSS_FRAMES_RESET,
                                            dds_pkg::SMOOTH_WEIGHT_RESET};
   // threshold, confirm count, loss count and weight all at zero
   localparam dds_pkg::cfg_type CFG_ZERO = '{16'h0000, 4'd0, 8'd0, 16'h0000};
   // every register at its top value
   localparam dds_pkg::cfg_type CFG_TOP = '{16'hFFFF, 4'd15, 8'd255, 16'hFFFF};
   localparam dds_pkg::result_type NO_TARGET = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_box_present = 1'b0;
   logic [15:0] req_confidence = '0;
   logic [15:0] req_box_x = '0;
   logic [15:0] req_box_y = '0;
   logic [15:0] req_box_width = '0;
   logic [15:0] req_box_height = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_target_present;
   logic [15:0] rsp_target_cx;
   logic [15:0] rsp_target_y;
   logic [15:0] rsp_target_w;
   logic [15:0] rsp_target_h;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = dds_pkg::REG_CONF_THRESHOLD;
   logic [15:0] csr_wdata = '0;

   detection_debounce_smoother_core dut (.*);

   always #5 clock = ~clock;

   // tracker state as the block should hold it
   dds_pkg::cfg_type shadow_cfg = CFG_RST;
   logic [3:0]  trk_seen = '0;
   logic [7:0]  trk_missed = '0;
   logic        trk_present = 1'b0;
   logic [15:0] flt_w = '0;
   logic [15:0] flt_h = '0;
   logic [15:0] hold_x = '0;
   logic [15:0] hold_y = '0;
   logic [15:0] hold_w = '0;
   logic [15:0] hold_h = '0;

   dds_pkg::result_type pending_results[$];
   int          mismatches = 0;
   int          send_idle = 0;
   int          recv_idle = 0;
   int          run_left = 0;
   logic        run_good = 1'b0;

   // directed steps
   step_row_type plan [22] = '{
      // no box at all, even with full confidence
      '{1'b0, CFG_RST, '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, NO_TARGET},
      // confidence equal to the threshold does not count
      '{1'b0, CFG_RST, '{1'b1, 16'h4000, 16'h1234, 16'h5678, 16'h0100, 16'h0200}, 1'b1, NO_TARGET},
      // four valid frames in a row, the fourth confirms and loads the size directly
      '{1'b0, CFG_RST, '{1'b1, 16'h4001, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001}, 1'b1, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b1, 16'h4001, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001}, 1'b1, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b1, 16'h4001, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001}, 1'b1, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b1, 16'h4001, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001},
        1'b1, '{1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001}},
      // filter pulled toward the opposite extremes
      '{1'b0, CFG_RST, '{1'b1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, 1'b0, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b1, 16'h8000, 16'h1111, 16'h2222, 16'h3333, 16'h4444}, 1'b0, NO_TARGET},
      // eight misses drop the target, held values stay
      '{1'b0, CFG_RST, '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b1, 16'h0000, 16'h9999, 16'h9999, 16'h9999, 16'h9999}, 1'b0, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b1, 16'h3FFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TARGET},
      '{1'b0, CFG_RST, '{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TARGET},
      // zero confirm count: first valid frame confirms; zero width keeps the filter unlocked
      '{1'b1, CFG_ZERO, '{1'b1, 16'h0001, 16'h0ABC, 16'h0DEF, 16'h0000, 16'h0123}, 1'b0, NO_TARGET},
      '{1'b0, CFG_ZERO, '{1'b1, 16'h0001, 16'h0456, 16'h0789, 16'h0456, 16'h0789}, 1'b0, NO_TARGET},
      // zero weight freezes the size
      '{1'b0, CFG_ZERO, '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b0, NO_TARGET},
      // zero loss count drops on the first miss
      '{1'b0, CFG_ZERO, '{1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, NO_TARGET},
      // top threshold: nothing can pass
      '{1'b1, CFG_TOP, '{1'b1, 16'hFFFF, 16'h7777, 16'h8888, 16'h1000, 16'h2000}, 1'b0, NO_TARGET},
      '{1'b0, CFG_TOP, '{1'b1, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003, 16'h0004}, 1'b0, NO_TARGET}
   };

   // first-order size filter, truncated
   function automatic logic [15:0] ema_blend(input logic [15:0] prev, input logic [15:0] fresh,
                                             input logic [15:0] weight);
      logic [32:0] acc;
      acc = 33'(prev) * (33'(dds_pkg::Q16_ONE) - 33'(weight)) + 33'(fresh) * 33'(weight);
      return acc[31:16];
   endfunction

   // debounce and smoothing step for one frame
   task automatic track_frame(input dds_pkg::item_type f, output dds_pkg::result_type r);
      logic good;
      good = f.box_present && (f.confidence > shadow_cfg.conf_threshold);
      if (good) begin
         trk_missed = '0;
         if (trk_seen < shadow_cfg.confirm_frames) trk_seen = trk_seen + 4'd1;
         if (trk_seen >= shadow_cfg.confirm_frames) begin
            trk_present = 1'b1;
            hold_x = f.box_x;
            hold_y = f.box_y;
            if (flt_w == 16'd0) begin
               flt_w = f.box_width;
               flt_h = f.box_height;
            end else begin
               flt_w = ema_blend(flt_w, f.box_width, shadow_cfg.smooth_weight);
               flt_h = ema_blend(flt_h, f.box_height, shadow_cfg.smooth_weight);
            end
            hold_w = flt_w;
            hold_h = flt_h;
         end
      end else begin
         trk_seen = '0;
         if (trk_present) begin
            if (trk_missed != dds_pkg::MISSED_MAX) trk_missed = trk_missed + 8'd1;
            if (trk_missed >= shadow_cfg.loss_frames) begin
               trk_present = 1'b0;
               flt_w = '0;
               flt_h = '0;
            end
         end
      end
      r.target_present = trk_present;
      r.target_cx = hold_x;
      r.target_y = hold_y;
      r.target_w = hold_w;
      r.target_h = hold_h;
   endtask

   // register writes, only once every result is back and the pipe has emptied
   task automatic write_settings(input dds_pkg::cfg_type c);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= dds_pkg::REG_CONF_THRESHOLD;
      csr_wdata <= c.conf_threshold;
      @(negedge clock);
      csr_index <= dds_pkg::REG_CONFIRM_FRAMES;
      csr_wdata <= {12'd0, c.confirm_frames};
      @(negedge clock);
      csr_index <= dds_pkg::REG_LOSS_FRAMES;
      csr_wdata <= {8'd0, c.loss_frames};
      @(negedge clock);
      csr_index <= dds_pkg::REG_SMOOTH_WEIGHT;
      csr_wdata <= c.smooth_weight;
      @(negedge clock);
      csr_write_en <= 1'b0;
      shadow_cfg = c;
   endtask

   // offer one item, record what it should produce, wait for it to be taken
   task automatic push_frame(input dds_pkg::item_type f, input logic typed,
                             input dds_pkg::result_type want);
      dds_pkg::result_type r;
      while ($urandom_range(99, 0) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_box_present <= f.box_present;
      req_confidence <= f.confidence;
      req_box_x <= f.box_x;
      req_box_y <= f.box_y;
      req_box_width <= f.box_width;
      req_box_height <= f.box_height;
      track_frame(f, r);
      pending_results.push_back(typed ? want : r);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_size();
      int roll;
      roll = $urandom_range(9, 0);
      if (roll == 0) return 16'h0000;
      if (roll == 1) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   // runs of passing and failing frames, with some noise mixed in
   task automatic next_frame(output dds_pkg::item_type f);
      logic [15:0] thr;
      thr = shadow_cfg.conf_threshold;
      f.box_present = 1'b1;
      f.confidence = 16'($urandom);
      f.box_x = 16'($urandom);
      f.box_y = 16'($urandom);
      f.box_width = pick_size();
      f.box_height = pick_size();
      if (run_left == 0) begin
         run_good = 1'($urandom_range(1, 0));
         run_left = run_good ? $urandom_range(int'(shadow_cfg.confirm_frames) + 8, 1)
                             : $urandom_range(int'(shadow_cfg.loss_frames) + 4, 1);
      end
      run_left--;
      if ($urandom_range(99, 0) < 15) begin
         f.box_present = 1'($urandom_range(1, 0));
      end else if (run_good && thr != 16'hFFFF) begin
         f.confidence = 16'($urandom_range(65535, int'(thr) + 1));
      end else if ($urandom_range(1, 0) == 1) begin
         f.box_present = 1'b0;
      end else begin
         f.confidence = 16'($urandom_range(int'(thr), 0));
      end
   endtask

   // register setting and length of each random phase
   task automatic pick_phase(input int seg, output dds_pkg::cfg_type c, output int count);
      c.conf_threshold = 16'($urandom);
      c.confirm_frames = 4'($urandom_range(15, 1));
      c.loss_frames = 8'($urandom_range(12, 1));
      c.smooth_weight = 16'($urandom);
      count = 200;
      case (seg)
         0: begin
            c.confirm_frames = 4'd1;
            c.loss_frames = 8'd1;
            c.smooth_weight = 16'hFFFF;
         end
         1: begin
            c = '{16'h0000, 4'd15, 8'd255, 16'h0000};
            count = 250;
         end
         3: begin
            c.conf_threshold = 16'($urandom_range(2000, 0));
            c.confirm_frames = 4'd0;
            c.loss_frames = 8'd0;
         end
         4: begin
            c.conf_threshold = 16'hFFFF;
            count = 30;
         end
         5: begin
            c.loss_frames = 8'($urandom_range(30, 1));
            count = 370;
         end
         default: ;
      endcase
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= recv_idle);
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   // compare each taken result with the oldest one waiting
   always @(posedge clock) begin
      dds_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected, expected none got %h", $time,
                     {rsp_target_present, rsp_target_cx, rsp_target_y, rsp_target_w,
                      rsp_target_h});
         end else begin
            want = pending_results.pop_front();
            check_field("target_present", 16'(want.target_present), 16'(rsp_target_present));
            check_field("target_cx", want.target_cx, rsp_target_cx);
            check_field("target_y", want.target_y, rsp_target_y);
            check_field("target_w", want.target_w, rsp_target_w);
            check_field("target_h", want.target_h, rsp_target_h);
         end
      end
   end

   // stimulus
   initial begin
      dds_pkg::item_type frame;
      dds_pkg::cfg_type  setting;
      int                count;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 38;
      recv_idle = 47;
      foreach (plan[i]) begin
         if (plan[i].load_cfg) write_settings(plan[i].cfg);
         push_frame(plan[i].frame, plan[i].typed, plan[i].want);
      end

      for (int seg = 0; seg < 6; seg++) begin
         pick_phase(seg, setting, count);
         write_settings(setting);
         if (seg < 2) begin
            send_idle = 38;
            recv_idle = 47;
         end else if (seg < 4) begin
            send_idle = 47;
            recv_idle = 38;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         run_left = 0;
         repeat (count) begin
            next_frame(frame);
            push_frame(frame, 1'b0, NO_TARGET);
         end
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0) begin
         $display("detection_debounce_smoother_core: match");
      end else begin
         $display("detection_debounce_smoother_core: mismatch");
      end
      $finish;
   end

   // hang guard
   initial begin
      #5000000;
      $display("detection_debounce_smoother_core: mismatch");
      $finish;
   end

endmodule

// ===== detection_debounce_smoother_core.f =====
design/dds_pkg.sv
design/dds_blend.sv
design/detection_debounce_smoother_core.sv
bench/detection_debounce_smoother_core_test.sv
